>>> hdl/ves_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ves_pkg
// Shared types and constants of the voxel ellipsoid sculpt block.
// ----------------------------------------------------------------------------
package ves_pkg;

    localparam int DEF_MAX_WIDTH  = 32;
    localparam int DEF_MAX_HEIGHT = 32;
    localparam int DEF_MAX_DEPTH  = 32;

    localparam int COORD_W = 8;
    localparam int DIV_DW  = 30;
    localparam int DIV_SW  = 22;

    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_FILL  = 2'd2;
    localparam logic [1:0] ACT_CARVE = 2'd3;

    localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [1:0] REG_GRID_DEPTH  = 2'd2;

    localparam logic [31:0] UNIT_SCALE  = 32'd1000;
    // x / 3921569 == (x * CARVE_RECIP) >> 52 for every x below 2^30
    localparam logic [31:0] CARVE_RECIP = 32'd1148417796;

    typedef struct packed {
        logic              start;
        logic [DIV_DW-1:0] dividend;
        logic [DIV_SW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_DW-1:0] quotient;
    } div_rsp_t;

endpackage

>>> hdl/voxel_ellipsoid_sculpt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_ellipsoid_sculpt
// Voxel volume edited by read, write, ellipsoid fill and soft carve commands.
// ----------------------------------------------------------------------------
// After reset the block clears its voxel memory, one entry per cycle, and
// takes no command meanwhile; configuration writes are taken at any time and
// apply from the next command accepted. One command is handled at a time;
// s_tready stays low until its result is loaded into the output register. A
// read runs S_WH, S_VOX, S_YW, S_RD, S_RD2 and S_RESP, a write S_WH, S_VOX,
// S_YW, S_WR and S_RESP, and an address outside the grid goes to S_RESP. An
// ellipsoid command walks every voxel of its clamped bounding box with one
// shared multiplier and one bit-serial divider: S_WH once, then per voxel
// S_VOX, S_YW, for each axis S_T2, S_T1K, S_RR and S_DIVW (which waits for
// the quotient), S_EVAL, for a soft carve S_W2, S_W3, S_RCPL and S_RCPH, whose
// constant divide is a reciprocal multiply, and S_NEXT; S_RESP gives the result.
module voxel_ellipsoid_sculpt #(
    parameter int MAX_WIDTH  = ves_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ves_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_DEPTH  = ves_pkg::DEF_MAX_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // action[1:0], center_x[11:2], center_y[21:12], center_z[31:22],
    // radius_x[39:32], radius_y[47:40], radius_z[55:48], fill_value[63:56]
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_value[7:0], status[8], zero[15:9]
    output logic [15:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_data
);
    import ves_pkg::*;

    localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT * MAX_DEPTH;
    localparam int IW = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;

    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_WH    = 5'd2;
    localparam logic [4:0] S_VOX   = 5'd3;
    localparam logic [4:0] S_YW    = 5'd4;
    localparam logic [4:0] S_RD    = 5'd5;
    localparam logic [4:0] S_RD2   = 5'd6;
    localparam logic [4:0] S_WR    = 5'd7;
    localparam logic [4:0] S_T2    = 5'd8;
    localparam logic [4:0] S_T1K   = 5'd9;
    localparam logic [4:0] S_RR    = 5'd10;
    localparam logic [4:0] S_DIVW  = 5'd11;
    localparam logic [4:0] S_EVAL  = 5'd12;
    localparam logic [4:0] S_W2    = 5'd13;
    localparam logic [4:0] S_W3    = 5'd14;
    localparam logic [4:0] S_RCPL  = 5'd15;
    localparam logic [4:0] S_NEXT  = 5'd16;
    localparam logic [4:0] S_RESP  = 5'd17;
    localparam logic [4:0] S_RCPH  = 5'd18;

    logic [4:0]  state_reg, state_next;
    logic [5:0]  gw_reg, gw_next, gh_reg, gh_next, gd_reg, gd_next;
    logic [1:0]  act_reg, act_next;
    logic signed [9:0] cen_reg [3];
    logic signed [9:0] cen_next [3];
    logic [7:0]  rad_reg [3];
    logic [7:0]  rad_next [3];
    logic [COORD_W-1:0] lo_reg [3];
    logic [COORD_W-1:0] lo_next [3];
    logic [COORD_W-1:0] hi_reg [3];
    logic [COORD_W-1:0] hi_next [3];
    logic [COORD_W-1:0] cur_reg [3];
    logic [COORD_W-1:0] cur_next [3];
    logic [7:0]  fill_reg, fill_next;
    logic [8:0]  w_reg, w_next, h_reg, h_next;
    logic [16:0] wh_reg, wh_next;
    logic [IW-1:0] zo_reg, zo_next, idx_reg, idx_next;
    logic [1:0]  axis_reg, axis_next;
    logic [31:0] acc_reg, acc_next;
    logic [29:0] p_reg, p_next;
    logic [29:0] rcp_reg, rcp_next;
    logic [9:0]  wt_reg, wt_next;
    logic [IW:0] clr_reg, clr_next;
    logic [7:0]  rd_reg;
    logic [7:0]  res_val_reg, res_val_next;
    logic        res_st_reg, res_st_next;
    logic        mv_reg, mv_next;
    logic [7:0]  mo_val_reg, mo_val_next;
    logic        mo_st_reg, mo_st_next;

    logic [31:0] mul_a;
    logic [15:0] mul_b;
    logic [47:0] prod;
    logic [45:0] rcp_sum;
    logic [9:0]  carve_dec;
    logic        mem_we;
    logic [IW-1:0] mem_addr;
    logic [7:0]  mem_wdata;
    logic [7:0]  mem [STORE_SIZE];
    div_req_t    div_req;
    div_rsp_t    div_rsp;

    logic [8:0]  dw, dh, dd;
    logic signed [11:0] in_c [3];
    logic [7:0]  in_r [3];
    logic [1:0]  in_act;
    logic        out_of_grid;
    logic signed [10:0] tdiff;
    logic [9:0]  tmag;

    function automatic logic [8:0] dim_use(input logic [5:0] r, input logic [8:0] mx);
        logic [8:0] d;
        d = {3'b0, r};
        if (d == 9'd0)
            d = 9'd1;
        if (d > mx)
            d = mx;
        return d;
    endfunction

    function automatic logic [COORD_W-1:0] clamp_dim(input logic signed [11:0] v,
                                                     input logic [8:0] dim);
        logic signed [11:0] top;
        logic [COORD_W-1:0] r;
        top = signed'({3'b0, dim}) - 12'sd1;
        if (v < 12'sd0)
            r = '0;
        else if (v > top)
            r = top[COORD_W-1:0];
        else
            r = v[COORD_W-1:0];
        return r;
    endfunction

    ves_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = mv_reg;
    assign m_tdata   = {7'b0, mo_st_reg, mo_val_reg};
    assign prod      = {16'b0, mul_a} * {32'b0, mul_b};

    always_comb
    begin
        dw = dim_use(gw_reg, 9'(MAX_WIDTH));
        dh = dim_use(gh_reg, 9'(MAX_HEIGHT));
        dd = dim_use(gd_reg, 9'(MAX_DEPTH));
        in_act  = s_tdata[1:0];
        in_c[0] = {{2{s_tdata[11]}}, s_tdata[11:2]};
        in_c[1] = {{2{s_tdata[21]}}, s_tdata[21:12]};
        in_c[2] = {{2{s_tdata[31]}}, s_tdata[31:22]};
        in_r[0] = (s_tdata[39:32] == 8'd0) ? 8'd1 : s_tdata[39:32];
        in_r[1] = (s_tdata[47:40] == 8'd0) ? 8'd1 : s_tdata[47:40];
        in_r[2] = (s_tdata[55:48] == 8'd0) ? 8'd1 : s_tdata[55:48];
        out_of_grid = (in_c[0] < 12'sd0) || (in_c[0] >= signed'({3'b0, dw})) ||
                      (in_c[1] < 12'sd0) || (in_c[1] >= signed'({3'b0, dh})) ||
                      (in_c[2] < 12'sd0) || (in_c[2] >= signed'({3'b0, dd}));
        tdiff = signed'({3'b0, cur_reg[axis_reg]}) - {cen_reg[axis_reg][9], cen_reg[axis_reg]};
        tmag  = tdiff[10] ? 10'(-tdiff) : tdiff[9:0];

        state_next = state_reg;
        gw_next = gw_reg;
        gh_next = gh_reg;
        gd_next = gd_reg;
        act_next = act_reg;
        fill_next = fill_reg;
        w_next = w_reg;
        h_next = h_reg;
        wh_next = wh_reg;
        zo_next = zo_reg;
        idx_next = idx_reg;
        axis_next = axis_reg;
        acc_next = acc_reg;
        p_next = p_reg;
        rcp_next = rcp_reg;
        wt_next = wt_reg;
        clr_next = clr_reg;
        res_val_next = res_val_reg;
        res_st_next = res_st_reg;
        mv_next = mv_reg;
        mo_val_next = mo_val_reg;
        mo_st_next = mo_st_reg;
        for (int k = 0; k < 3; k++)
        begin
            cen_next[k] = cen_reg[k];
            rad_next[k] = rad_reg[k];
            lo_next[k]  = lo_reg[k];
            hi_next[k]  = hi_reg[k];
            cur_next[k] = cur_reg[k];
        end
        mul_a = '0;
        mul_b = '0;
        rcp_sum = '0;
        carve_dec = '0;
        mem_we = 1'b0;
        mem_addr = idx_reg;
        mem_wdata = fill_reg;
        div_req.start = 1'b0;
        div_req.dividend = p_reg;
        div_req.divisor = '0;

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_GRID_WIDTH:  gw_next = cfg_data;
                REG_GRID_HEIGHT: gh_next = cfg_data;
                REG_GRID_DEPTH:  gd_next = cfg_data;
                default: ;
            endcase
        end

        if (mv_reg && m_tready)
            mv_next = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                mem_addr = clr_reg[IW-1:0];
                mem_wdata = 8'd0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (IW+1)'(STORE_SIZE - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    act_next = in_act;
                    fill_next = s_tdata[63:56];
                    w_next = dw;
                    h_next = dh;
                    res_val_next = 8'd0;
                    res_st_next = 1'b0;
                    for (int k = 0; k < 3; k++)
                    begin
                        cen_next[k] = in_c[k][9:0];
                        rad_next[k] = in_r[k];
                    end
                    lo_next[0] = clamp_dim(in_c[0] - signed'({4'b0, in_r[0]}), dw);
                    hi_next[0] = clamp_dim(in_c[0] + signed'({4'b0, in_r[0]}), dw);
                    lo_next[1] = clamp_dim(in_c[1] - signed'({4'b0, in_r[1]}), dh);
                    hi_next[1] = clamp_dim(in_c[1] + signed'({4'b0, in_r[1]}), dh);
                    lo_next[2] = clamp_dim(in_c[2] - signed'({4'b0, in_r[2]}), dd);
                    hi_next[2] = clamp_dim(in_c[2] + signed'({4'b0, in_r[2]}), dd);
                    if (in_act == ACT_READ || in_act == ACT_WRITE)
                    begin
                        for (int k = 0; k < 3; k++)
                            cur_next[k] = in_c[k][COORD_W-1:0];
                        if (out_of_grid)
                        begin
                            res_st_next = 1'b1;
                            state_next = S_RESP;
                        end
                        else
                            state_next = S_WH;
                    end
                    else
                    begin
                        cur_next[0] = clamp_dim(in_c[0] - signed'({4'b0, in_r[0]}), dw);
                        cur_next[1] = clamp_dim(in_c[1] - signed'({4'b0, in_r[1]}), dh);
                        cur_next[2] = clamp_dim(in_c[2] - signed'({4'b0, in_r[2]}), dd);
                        state_next = S_WH;
                    end
                end
            end
            S_WH:
            begin
                mul_a = {23'b0, w_reg};
                mul_b = {7'b0, h_reg};
                wh_next = prod[16:0];
                state_next = S_VOX;
            end
            S_VOX:
            begin
                mul_a = {15'b0, wh_reg};
                mul_b = {8'b0, cur_reg[2]};
                zo_next = prod[IW-1:0];
                state_next = S_YW;
            end
            S_YW:
            begin
                mul_a = {23'b0, w_reg};
                mul_b = {8'b0, cur_reg[1]};
                idx_next = zo_reg + prod[IW-1:0] + IW'(cur_reg[0]);
                axis_next = 2'd0;
                acc_next = '0;
                case (act_reg)
                    ACT_READ:  state_next = S_RD;
                    ACT_WRITE: state_next = S_WR;
                    default:   state_next = S_T2;
                endcase
            end
            S_RD:
                state_next = S_RD2;
            S_RD2:
            begin
                res_val_next = rd_reg;
                state_next = S_RESP;
            end
            S_WR:
            begin
                mem_we = 1'b1;
                state_next = S_RESP;
            end
            S_T2:
            begin
                mul_a = {22'b0, tmag};
                mul_b = {6'b0, tmag};
                p_next = prod[29:0];
                state_next = S_T1K;
            end
            S_T1K:
            begin
                mul_a = {2'b0, p_reg};
                mul_b = UNIT_SCALE[15:0];
                p_next = prod[29:0];
                state_next = S_RR;
            end
            S_RR:
            begin
                mul_a = {24'b0, rad_reg[axis_reg]};
                mul_b = {8'b0, rad_reg[axis_reg]};
                div_req.start = 1'b1;
                div_req.dividend = p_reg;
                div_req.divisor = prod[DIV_SW-1:0];
                state_next = S_DIVW;
            end
            S_DIVW:
            begin
                if (div_rsp.done)
                begin
                    acc_next = acc_reg + {2'b0, div_rsp.quotient};
                    axis_next = axis_reg + 1'b1;
                    state_next = (axis_reg == 2'd2) ? S_EVAL : S_T2;
                end
            end
            S_EVAL:
            begin
                if (act_reg == ACT_FILL)
                begin
                    mem_we = (acc_reg <= UNIT_SCALE);
                    state_next = S_NEXT;
                end
                else
                begin
                    wt_next = (acc_reg < UNIT_SCALE) ? 10'(UNIT_SCALE - acc_reg) : 10'd0;
                    state_next = S_W2;
                end
            end
            S_W2:
            begin
                mul_a = {22'b0, wt_reg};
                mul_b = {6'b0, wt_reg};
                p_next = prod[29:0];
                state_next = S_W3;
            end
            S_W3:
            begin
                mul_a = {2'b0, p_reg};
                mul_b = {6'b0, wt_reg};
                p_next = prod[29:0];
                state_next = S_RCPL;
            end
            S_RCPL:
            begin
                mul_a = {2'b0, p_reg};
                mul_b = CARVE_RECIP[15:0];
                rcp_next = prod[45:16];
                state_next = S_RCPH;
            end
            S_RCPH:
            begin
                mul_a = {2'b0, p_reg};
                mul_b = CARVE_RECIP[31:16];
                rcp_sum = prod[45:0] + {16'b0, rcp_reg};
                carve_dec = rcp_sum[45:36];
                mem_we = 1'b1;
                mem_wdata = ({2'b0, rd_reg} > carve_dec) ? (rd_reg - carve_dec[7:0]) : 8'd0;
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                state_next = S_VOX;
                if (cur_reg[0] != hi_reg[0])
                    cur_next[0] = cur_reg[0] + 1'b1;
                else
                begin
                    cur_next[0] = lo_reg[0];
                    if (cur_reg[1] != hi_reg[1])
                        cur_next[1] = cur_reg[1] + 1'b1;
                    else
                    begin
                        cur_next[1] = lo_reg[1];
                        if (cur_reg[2] != hi_reg[2])
                            cur_next[2] = cur_reg[2] + 1'b1;
                        else
                            state_next = S_RESP;
                    end
                end
            end
            S_RESP:
            begin
                if (!mv_reg || m_tready)
                begin
                    mv_next = 1'b1;
                    mo_val_next = res_val_reg;
                    mo_st_next = res_st_reg;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            gw_reg    <= 6'd32;
            gh_reg    <= 6'd32;
            gd_reg    <= 6'd32;
            mv_reg    <= 1'b0;
            axis_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            gw_reg    <= gw_next;
            gh_reg    <= gh_next;
            gd_reg    <= gd_next;
            mv_reg    <= mv_next;
            axis_reg  <= axis_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg     <= act_next;
        fill_reg    <= fill_next;
        w_reg       <= w_next;
        h_reg       <= h_next;
        wh_reg      <= wh_next;
        zo_reg      <= zo_next;
        idx_reg     <= idx_next;
        acc_reg     <= acc_next;
        p_reg       <= p_next;
        rcp_reg     <= rcp_next;
        wt_reg      <= wt_next;
        res_val_reg <= res_val_next;
        res_st_reg  <= res_st_next;
        mo_val_reg  <= mo_val_next;
        mo_st_reg   <= mo_st_next;
        for (int k = 0; k < 3; k++)
        begin
            cen_reg[k] <= cen_next[k];
            rad_reg[k] <= rad_next[k];
            lo_reg[k]  <= lo_next[k];
            hi_reg[k]  <= hi_next[k];
            cur_reg[k] <= cur_next[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        rd_reg <= mem[idx_reg];
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (state_reg == S_IDLE))
        else $error("command taken outside idle");

    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider restarted while busy");

    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[8]) |-> (m_tdata[7:0] == 8'd0))
        else $error("error status with nonzero read value");

    a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg != S_CLEAR) |-> ({1'b0, mem_addr} < (IW+1)'(STORE_SIZE)))
        else $error("voxel write beyond store");

endmodule

>>> hdl/ves_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ves_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ves_div (
    input  logic              clk,
    input  logic              rst_n,
    input  ves_pkg::div_req_t req,
    output ves_pkg::div_rsp_t rsp
);
    import ves_pkg::*;

    localparam int CNT_W = $clog2(DIV_DW + 1);

    logic [DIV_SW:0]   rem_reg, rem_next;
    logic [DIV_DW-1:0] dvd_reg, dvd_next;
    logic [DIV_SW-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_SW+1:0] trial;
    logic [DIV_SW:0]   shifted;

    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[DIV_SW-1:0], dvd_reg[DIV_DW-1]};
        trial     = {1'b0, shifted} - {2'b0, dvs_reg};
        if (req.start)
        begin
            rem_next  = '0;
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = CNT_W'(DIV_DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DIV_SW+1])
            begin
                rem_next = trial[DIV_SW:0];
                dvd_next = {dvd_reg[DIV_DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                dvd_next = {dvd_reg[DIV_DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule

>>> verif/voxel_ellipsoid_sculpt_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_ellipsoid_sculpt_tb
// Self-checking bench for the voxel ellipsoid sculpt block. A local voxel
// model predicts each result of read, write, fill and soft carve commands
// under several grid sizes. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module voxel_ellipsoid_sculpt_tb;
    import ves_pkg::*;

    localparam int MAXW = 32;
    localparam int MAXH = 32;
    localparam int MAXD = 32;
    localparam int STORE_SZ = MAXW * MAXH * MAXD;
    localparam int STALL_LIMIT = 400000;

    typedef struct packed {
        logic [7:0] fill;
        logic [7:0] rz;
        logic [7:0] ry;
        logic [7:0] rx;
        logic [9:0] cz;
        logic [9:0] cy;
        logic [9:0] cx;
        logic [1:0] act;
    } cmd_t;

    typedef struct packed {
        logic [6:0] pad;
        logic       status;
        logic [7:0] read_value;
    } rsp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_GRID_WIDTH;
    logic [5:0]  cfg_data = '0;

    logic [7:0]  voxels [STORE_SZ];
    logic [5:0]  grid_reg [3];
    rsp_t        pending_rsp [$];
    int          errors = 0;
    int          stall_cnt = 0;
    bit          no_idle = 0;

    voxel_ellipsoid_sculpt uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    function automatic int dim_of(int i, int maxv);
        int d;
        d = grid_reg[i];
        if (d < 1) d = 1;
        if (d > maxv) d = maxv;
        return d;
    endfunction

    function automatic int clampi(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint term(int t, longint r);
        longint m;
        m = (t < 0) ? -t : t;
        return (m * m * 1000) / (r * r);
    endfunction

    function automatic rsp_t sculpt_predict(cmd_t c);
        rsp_t   r;
        int     w, h, d, cx, cy, cz;
        longint ra, rb, rc, s, wt, dec;
        int     x0, x1, y0, y1, z0, z1, idx;
        r = '0;
        w = dim_of(0, MAXW);
        h = dim_of(1, MAXH);
        d = dim_of(2, MAXD);
        cx = $signed(c.cx);
        cy = $signed(c.cy);
        cz = $signed(c.cz);
        ra = (c.rx == 0) ? 1 : c.rx;
        rb = (c.ry == 0) ? 1 : c.ry;
        rc = (c.rz == 0) ? 1 : c.rz;
        if (c.act == ACT_READ || c.act == ACT_WRITE) begin
            if (cx < 0 || cx >= w || cy < 0 || cy >= h || cz < 0 || cz >= d)
                r.status = 1'b1;
            else begin
                idx = cz * w * h + cy * w + cx;
                if (c.act == ACT_READ)
                    r.read_value = voxels[idx];
                else
                    voxels[idx] = c.fill;
            end
        end else begin
            x0 = clampi(cx - int'(ra), 0, w - 1);
            x1 = clampi(cx + int'(ra), 0, w - 1);
            y0 = clampi(cy - int'(rb), 0, h - 1);
            y1 = clampi(cy + int'(rb), 0, h - 1);
            z0 = clampi(cz - int'(rc), 0, d - 1);
            z1 = clampi(cz + int'(rc), 0, d - 1);
            for (int x = x0; x <= x1; x++)
                for (int y = y0; y <= y1; y++)
                    for (int z = z0; z <= z1; z++) begin
                        s = term(x - cx, ra) + term(y - cy, rb) + term(z - cz, rc);
                        idx = z * w * h + y * w + x;
                        if (c.act == ACT_FILL) begin
                            if (s <= 1000)
                                voxels[idx] = c.fill;
                        end else begin
                            wt = (s < 1000) ? 1000 - s : 0;
                            dec = (wt * wt * wt) / 3921569;
                            voxels[idx] = (voxels[idx] > dec) ?
                                          8'(voxels[idx] - dec) : 8'd0;
                        end
                    end
        end
        return r;
    endfunction

    task automatic random_gap();
        if (!no_idle && $urandom_range(99) < 14) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
    endtask

    task automatic send_cmd(cmd_t c);
        random_gap();
        s_tvalid <= 1'b1;
        s_tdata <= c;
        do @(posedge clk); while (!s_tready);
        pending_rsp.insert(pending_rsp.size(), sculpt_predict(c));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [5:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        grid_reg[index] = value;
    endtask

    task automatic set_grid(logic [5:0] w, logic [5:0] h, logic [5:0] d);
        write_reg(REG_GRID_WIDTH, w);
        write_reg(REG_GRID_HEIGHT, h);
        write_reg(REG_GRID_DEPTH, d);
    endtask

    function automatic cmd_t mk(logic [1:0] a, int x, int y, int z,
                                int rx, int ry, int rz, int f);
        cmd_t c;
        c.act = a;
        c.cx = x[9:0];
        c.cy = y[9:0];
        c.cz = z[9:0];
        c.rx = rx[7:0];
        c.ry = ry[7:0];
        c.rz = rz[7:0];
        c.fill = f[7:0];
        return c;
    endfunction

    // small grids only: every ellipsoid box is clamped to at most 4x4x4
    function automatic cmd_t rand_cmd(bit voxel_only);
        cmd_t c;
        c = {$urandom(), $urandom()};
        c.act = voxel_only ? 2'($urandom_range(1)) : 2'($urandom_range(3));
        c.fill = 8'($urandom());
        c.rx = 8'($urandom());
        c.ry = 8'($urandom());
        c.rz = 8'($urandom());
        if ($urandom_range(99) < 80) begin
            c.cx = 10'($urandom_range(dim_of(0, MAXW) - 1));
            c.cy = 10'($urandom_range(dim_of(1, MAXH) - 1));
            c.cz = 10'($urandom_range(dim_of(2, MAXD) - 1));
        end
        return c;
    endfunction

    task automatic test_after_reset();
        send_cmd(mk(ACT_READ, 0, 0, 0, 1, 1, 1, 0));
        send_cmd(mk(ACT_WRITE, 31, 31, 31, 1, 1, 1, 255));
        send_cmd(mk(ACT_READ, 31, 31, 31, 1, 1, 1, 0));
        send_cmd(mk(ACT_WRITE, 0, 0, 0, 1, 1, 1, 0));
        send_cmd(mk(ACT_WRITE, 32, 0, 0, 1, 1, 1, 7));
        send_cmd(mk(ACT_READ, -1, 0, 0, 1, 1, 1, 0));
        send_cmd(mk(ACT_READ, 511, 511, 511, 1, 1, 1, 0));
        send_cmd(mk(ACT_WRITE, -512, -512, -512, 1, 1, 1, 9));
        send_cmd(mk(ACT_FILL, 10, 10, 10, 1, 1, 1, 200));
        send_cmd(mk(ACT_CARVE, 10, 10, 11, 1, 1, 1, 0));
        send_cmd(mk(ACT_READ, 10, 10, 10, 1, 1, 1, 0));
    endtask

    task automatic test_dim_extremes();
        set_grid(6'd63, 6'd63, 6'd63);
        send_cmd(mk(ACT_READ, 31, 31, 31, 1, 1, 1, 0));
        send_cmd(mk(ACT_WRITE, 0, 31, 32, 1, 1, 1, 3));
        set_grid(6'd0, 6'd0, 6'd0);
        send_cmd(mk(ACT_WRITE, 0, 0, 0, 1, 1, 1, 128));
        send_cmd(mk(ACT_READ, 1, 0, 0, 1, 1, 1, 0));
        send_cmd(mk(ACT_CARVE, 0, 0, 0, 255, 255, 255, 0));
        send_cmd(mk(ACT_READ, 0, 0, 0, 1, 1, 1, 0));
    endtask

    task automatic test_ellipsoid_cases();
        set_grid(6'd4, 6'd3, 6'd4);
        send_cmd(mk(ACT_FILL, 1, 1, 1, 0, 0, 0, 255));
        send_cmd(mk(ACT_FILL, 2, 1, 2, 255, 255, 255, 77));
        send_cmd(mk(ACT_CARVE, 0, 0, 0, 2, 0, 3, 0));
        send_cmd(mk(ACT_FILL, -40, 200, -512, 5, 5, 5, 11));
        send_cmd(mk(ACT_CARVE, 511, 1, 1, 255, 1, 1, 0));
        send_cmd(mk(ACT_READ, 3, 2, 3, 1, 1, 1, 0));
        send_cmd(mk(ACT_READ, 0, 0, 0, 1, 1, 1, 0));
    endtask

    task automatic test_random();
        for (int p = 0; p < 4; p++) begin
            set_grid(6'($urandom_range(4)), 6'($urandom_range(4, 1)),
                     6'($urandom_range(4, 1)));
            no_idle = (p == 2);
            for (int i = 0; i < 16; i++) begin
                if (p == 1 && i == 8)
                    drain();
                send_cmd(rand_cmd(1'b0));
            end
        end
        no_idle = 0;
        set_grid(6'd32, 6'd32, 6'd32);
        for (int i = 0; i < 12; i++)
            send_cmd(rand_cmd(1'b1));
        send_cmd(mk(ACT_FILL, $urandom_range(31), $urandom_range(31), 5, 1, 2, 1, 99));
        send_cmd(mk(ACT_CARVE, 5, $urandom_range(31), 6, 1, 1, 2, 0));
    endtask

    always @(posedge clk) begin
        rsp_t got, exp_rsp;
        if (m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected result beat %h", $realtime, m_tdata);
                errors++;
            end else begin
                exp_rsp = pending_rsp.pop_front();
                if (got.read_value !== exp_rsp.read_value) begin
                    $display("%0t: read_value expected %0d actual %0d", $realtime,
                             exp_rsp.read_value, got.read_value);
                    errors++;
                end
                if (got.status !== exp_rsp.status) begin
                    $display("%0t: status expected %0d actual %0d", $realtime,
                             exp_rsp.status, got.status);
                    errors++;
                end
                if (got.pad !== 7'd0) begin
                    $display("%0t: pad expected 0 actual %h", $realtime, got.pad);
                    errors++;
                end
            end
        end
        m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 14);
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < STORE_SZ; i++)
            voxels[i] = 8'd0;
        for (int i = 0; i < 3; i++)
            grid_reg[i] = 6'd32;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_after_reset();
        test_dim_extremes();
        test_ellipsoid_cases();
        test_random();
        drain();
        repeat (50) @(posedge clk);
        if (errors == 0 && pending_rsp.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

>>> sim.f
hdl/ves_pkg.sv
hdl/ves_div.sv
hdl/voxel_ellipsoid_sculpt.sv
verif/voxel_ellipsoid_sculpt_tb.sv
